// ----- rtl/rolling_checksum_tag_search_core_defines.svh -----
// assertion macros for the rolling checksum tag search core
// expects clk and rst in the scope of each use; no other dependencies
`ifndef ROLLING_CHECKSUM_TAG_SEARCH_CORE_DEFINES_SVH
`define ROLLING_CHECKSUM_TAG_SEARCH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// condition that must hold at every clock edge outside reset
`define RCTS_ASSERT_HOLD(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rcts assertion failed");
// same-cycle implication
`define RCTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcts assertion failed");
`else
`define RCTS_ASSERT_HOLD(label, expr)
`define RCTS_ASSERT_IMP(label, ante, cons)
`endif
`endif

// ----- rtl/rcts_pkg.sv -----
// shared types and constants for the rolling checksum tag search core
// no dependencies
`default_nettype none
package rcts_pkg;

  localparam int SUM_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int TAG_BITS   = 16;
  localparam int APB_ADDR_W = 3;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_PREFIX = 2'd1;
  localparam logic [1:0] MODE_ROLL   = 2'd2;
  localparam logic [1:0] MODE_WRITE  = 2'd3;

  // register index taken from paddr above the byte offset
  localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LEN = '0;

  localparam logic [SUM_W-1:0] WINDOW_LEN_RESET = 16'd1024;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } sums_t;

  typedef struct packed {
    logic                rd;
    logic                wr;
    logic [TAG_BITS-1:0] addr;
    logic                wdata;
  } tag_req_t;

endpackage
`default_nettype wire

// ----- rtl/rcts_ram.sv -----
// generic single-port synchronous ram, registered read data
// no dependencies
`default_nettype none
module rcts_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rcts_sum_unit.sv -----
// two running sums with clear, prefix and roll updates
// depends on rcts_pkg
`default_nettype none
module rcts_sum_unit
  import rcts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [1:0]        mode,
  input  logic [BYTE_W-1:0] new_byte,
  input  logic [BYTE_W-1:0] old_byte,
  input  logic [SUM_W-1:0]  window_len,
  output sums_t             acc
);

  sums_t                     acc_next;
  logic [SUM_W+BYTE_W-1:0]   weight_full;
  logic [SUM_W-1:0]          a_roll;

  assign weight_full = {{BYTE_W{1'b0}}, window_len} * {{SUM_W{1'b0}}, old_byte};
  assign a_roll = acc.a + {{(SUM_W-BYTE_W){1'b0}}, new_byte}
                        - {{(SUM_W-BYTE_W){1'b0}}, old_byte};

  always_comb begin
    acc_next = acc;
    case (mode)
      MODE_CLEAR: begin
        acc_next.a = '0;
        acc_next.b = '0;
      end
      MODE_PREFIX: begin
        acc_next.a = acc.a + {{(SUM_W-BYTE_W){1'b0}}, new_byte};
        acc_next.b = acc.b + acc_next.a;
      end
      MODE_ROLL: begin
        acc_next.a = a_roll;
        acc_next.b = acc.b + a_roll - weight_full[SUM_W-1:0];
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (load) begin
      acc <= acc_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rcts_tag_store.sv -----
// tag bit memory with the clearing pass after reset
// depends on rcts_pkg and rcts_ram
`default_nettype none
module rcts_tag_store
  import rcts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tag_req_t req,
  output logic     busy,
  output logic     rdata
);

  logic [TAG_BITS-1:0] clr_idx;
  logic                ram_we;
  logic                ram_re;
  logic [TAG_BITS-1:0] ram_addr;
  logic                ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + {{(TAG_BITS-1){1'b0}}, 1'b1};
      if (&clr_idx) begin
        busy <= 1'b0;
      end
    end
  end

  // clearing owns the port while busy
  assign ram_we    = busy | req.wr;
  assign ram_re    = ~busy & req.rd;
  assign ram_addr  = busy ? clr_idx : req.addr;
  assign ram_wdata = busy ? 1'b0 : req.wdata;

  rcts_ram #(
    .ADDR_W (TAG_BITS),
    .DATA_W (1)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

endmodule
`default_nettype wire

// ----- rtl/rolling_checksum_tag_search_core.sv -----
// top level of the rolling checksum tag search core
// depends on rcts_pkg, rcts_sum_unit, rcts_tag_store and the defines header
//
//   channel   handshake            payload
//   input     in_valid / in_ready  mode, new_byte, old_byte, tag_index, tag_value
//   result    out_valid/out_ready  hit, tag, sum_a, sum_b
//   config    apb write/read       window_len at byte address 0
//
// one item per cycle sustained unless a stalled result or the clearing pass stops input;
// a result is valid once its item has passed the second stage and the result register
// (sum update at transfer, tag ram access in the second stage, result register)
// the sum feedback adds a 16x8 product of window_len and the leaving byte
// after reset a clearing pass zeroes all 65536 (2**TAG_BITS) tag bits, during which no
// input transfer is taken; configuration is taken as ever; a stalled result holds the
// output stage, and the second stage still takes one more item before in_ready drops
`default_nettype none
`include "rolling_checksum_tag_search_core_defines.svh"
module rolling_checksum_tag_search_core
  import rcts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [BYTE_W-1:0]     new_byte,
  input  logic [BYTE_W-1:0]     old_byte,
  input  logic [SUM_W-1:0]      tag_index,
  input  logic                  tag_value,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [SUM_W-1:0]      tag,
  output logic [SUM_W-1:0]      sum_a,
  output logic [SUM_W-1:0]      sum_b,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration register
  logic [SUM_W-1:0] window_len;
  logic             cfg_wr;
  logic             cfg_sel;

  // pipeline control
  logic in_xfer;
  logic adv;            // second stage moves into the output stage
  logic busy;

  // second stage: sums live in the sum unit, the item's control here
  logic                s1_valid;
  logic [1:0]          s1_mode;
  logic [TAG_BITS-1:0] s1_tidx;
  logic                s1_tval;
  logic [TAG_BITS-1:0] s1_tag;
  sums_t               acc;

  // output stage
  logic                s2_roll;
  logic [TAG_BITS-1:0] s2_tag;
  sums_t               s2_sums;
  logic                tag_bit;

  tag_req_t ram_req;

  // apb: single register, low address bits are the byte offset
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN);
  assign cfg_wr  = psel & penable & pwrite & cfg_sel;
  assign prdata  = cfg_sel ? {{(32-SUM_W){1'b0}}, window_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_wr) begin
      window_len <= pwdata[SUM_W-1:0];
    end
  end

  // handshake: output stage frees when empty or taken
  assign adv      = ~out_valid | out_ready;
  assign in_ready = ~busy & (~s1_valid | adv);
  assign in_xfer  = in_valid & in_ready;

  rcts_sum_unit u_sum (
    .clk        (clk),
    .rst        (rst),
    .load       (in_xfer),
    .mode       (mode),
    .new_byte   (new_byte),
    .old_byte   (old_byte),
    .window_len (window_len),
    .acc        (acc)
  );

  // the sum registers always hold the sums of the newest item,
  // which is the one in the second stage whenever that is occupied
  assign s1_tag = acc.a[TAG_BITS-1:0] ^ acc.b[TAG_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode <= mode;
      s1_tidx <= tag_index[TAG_BITS-1:0];
      s1_tval <= tag_value;
    end
  end

  // tag ram access as the item leaves the second stage; only one item is
  // there, so a write always lands before any later lookup
  always_comb begin
    ram_req.rd    = adv & s1_valid & (s1_mode == MODE_ROLL);
    ram_req.wr    = adv & s1_valid & (s1_mode == MODE_WRITE);
    ram_req.addr  = (s1_mode == MODE_WRITE) ? s1_tidx : s1_tag;
    ram_req.wdata = s1_tval;
  end

  rcts_tag_store u_tags (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .busy  (busy),
    .rdata (tag_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv & s1_valid) begin
      s2_roll <= (s1_mode == MODE_ROLL);
      s2_tag  <= s1_tag;
      s2_sums <= acc;
    end
  end

  // ram read data holds while the output stage is stalled
  assign hit   = s2_roll & tag_bit;
  assign tag   = SUM_W'(s2_tag);
  assign sum_a = s2_sums.a;
  assign sum_b = s2_sums.b;

  // no transfer is taken while the tag ram is being cleared
  `RCTS_ASSERT_IMP(a_no_xfer_busy, busy, !in_ready)
  // a result only appears after an item sat in the second stage
  `RCTS_ASSERT_IMP(a_out_from_s1, $rose(out_valid), $past(s1_valid))
  // both stages full and stalled: input must be held off
  `RCTS_ASSERT_IMP(a_full_stall, out_valid && !out_ready && s1_valid, !in_ready)
  // the ram never sees a lookup and a tag write together
  `RCTS_ASSERT_HOLD(a_ram_excl, !(ram_req.rd && ram_req.wr))

endmodule
`default_nettype wire
